[rtl/bounded_deque_with_insert_core_defines.svh]
// assertion macros for the bounded deque core
`ifndef BOUNDED_DEQUE_WITH_INSERT_CORE_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_INSERT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define BDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked during reset too
`define BDQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BDQ_ASSERT(lbl, prop, msg)
`define BDQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/bdq_pkg.sv]
// shared constants for the bounded deque core
package bdq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int KIND_W       = 3;
  localparam int POS_W        = 4;
  localparam int STATUS_W     = 2;
  localparam int OUT_CNT_W    = 5;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

endpackage

[rtl/bdq_if.sv]
// request and result channel interfaces for the bounded deque core
interface bdq_in_if import bdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, output kind, output value, output position, input ready);
  modport sink   (input valid, input kind, input value, input position, output ready);
endinterface

interface bdq_out_if import bdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] popped_value;
  logic [STATUS_W-1:0]      status;
  logic [OUT_CNT_W-1:0]     count;

  modport source (output valid, output popped_value, output status, output count, input ready);
  modport sink   (input valid, input popped_value, input status, input count, output ready);
endinterface

[rtl/bounded_deque_with_insert_core.sv]
// Bounded deque of signed 32-bit values with push/pop at both ends and insert
// before an index. Entries live in a circular buffer in one RAM, addressed
// through a single modulo-capacity index unit, under a small sequencer that
// handles one request at a time. A refused or ignored request goes straight to
// the result; a push writes the RAM once, a pop reads it and registers the
// entry, and an insert first moves each entry behind the insert point one slot
// with one RAM read and one RAM write, then writes the new value. The result
// stays in an output register while out_ready is low, until taken; in_ready is
// high only between requests.
`include "bounded_deque_with_insert_core_defines.svh"

module bounded_deque_with_insert_core import bdq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bdq_in_if.sink    in_req,
  bdq_out_if.source out_rsp
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] CAP_M1  = IDX_W'(CAPACITY - 1);
  localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_WR   = 7'b0000010,
    S_RD   = 7'b0000100,
    S_POP  = 7'b0001000,
    S_SHR  = 7'b0010000,
    S_SHW  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [IDX_W-1:0]         head_r, head_nxt;
  logic [IDX_W-1:0]         off_r, off_nxt;
  logic [KIND_W-1:0]        kind_r, kind_nxt;
  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic signed [DATA_W-1:0] popped_r, popped_nxt;
  logic [STATUS_W-1:0]      status_r, status_nxt;

  logic [IDX_W-1:0]  addr_off;
  logic [IDX_W-1:0]  phys;
  logic              ram_we;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [DATA_W-1:0] ram_rdata;
  logic              full;
  logic              empty;
  logic [CMP_W-1:0]  pos_cmp;
  logic [CMP_W-1:0]  cnt_cmp;
  logic [CMP_W-1:0]  off_dec_cmp;
  logic [IDX_W-1:0]  off_dec;
  logic [CNT_W+OUT_CNT_W-1:0] cnt_ext;

  assign full    = (count_r == CAP_CNT);
  assign empty   = (count_r == '0);
  assign off_dec = off_r - IDX_ONE;

  // every ram address and head move goes through the one index unit
  always_comb begin
    unique case (state_r)
      S_IDLE:  addr_off = CAP_M1;
      S_POP:   addr_off = IDX_ONE;
      S_SHR:   addr_off = off_dec;
      default: addr_off = off_r;
    endcase
  end

  bdq_addr #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_addr (
    .base (head_r),
    .off  (addr_off),
    .phys (phys)
  );

  assign ram_we    = (state_r == S_WR) || (state_r == S_SHW);
  assign ram_wdata = (state_r == S_SHW) ? ram_rdata : DATA_W'(value_r);
  assign ram_re    = (state_r == S_RD) || (state_r == S_SHR);

  bdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (phys),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (phys),
    .rdata (ram_rdata)
  );

  assign pos_cmp     = CMP_W'(in_req.position);
  assign cnt_cmp     = CMP_W'(count_r);
  assign off_dec_cmp = CMP_W'(off_dec);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    head_nxt   = head_r;
    off_nxt    = off_r;
    kind_nxt   = kind_r;
    value_nxt  = value_r;
    pos_nxt    = pos_r;
    popped_nxt = popped_r;
    status_nxt = status_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          kind_nxt   = in_req.kind;
          value_nxt  = in_req.value;
          pos_nxt    = in_req.position;
          popped_nxt = '0;
          status_nxt = ST_OK;
          state_nxt  = S_OUT;
          unique case (in_req.kind) inside
            KIND_PUSH_FRONT: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                head_nxt  = phys;
                off_nxt   = '0;
                state_nxt = S_WR;
              end
            end
            KIND_PUSH_BACK: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                off_nxt   = IDX_W'(count_r);
                state_nxt = S_WR;
              end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                off_nxt   = (in_req.kind == KIND_POP_FRONT) ? '0 : IDX_W'(count_r - CNT_ONE);
                state_nxt = S_RD;
              end
            end
            KIND_INSERT: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else if (pos_cmp >= cnt_cmp) begin
                status_nxt = ST_BADIDX;
              end else begin
                // open the gap from the back, one entry per read/write pair
                off_nxt   = IDX_W'(count_r);
                state_nxt = S_SHR;
              end
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_WR: begin
        count_nxt = count_r + CNT_ONE;
        state_nxt = S_OUT;
      end
      S_RD: begin
        state_nxt = S_POP;
      end
      S_POP: begin
        popped_nxt = ram_rdata;
        count_nxt  = count_r - CNT_ONE;
        if (kind_r == KIND_POP_FRONT) begin
          head_nxt = phys;
        end
        state_nxt = S_OUT;
      end
      S_SHR: begin
        state_nxt = S_SHW;
      end
      S_SHW: begin
        off_nxt = off_dec;
        if (off_dec_cmp == CMP_W'(pos_r)) begin
          state_nxt = S_WR;
        end else begin
          state_nxt = S_SHR;
        end
      end
      S_OUT: begin
        if (out_rsp.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      head_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r    <= off_nxt;
    kind_r   <= kind_nxt;
    value_r  <= value_nxt;
    pos_r    <= pos_nxt;
    popped_r <= popped_nxt;
    status_r <= status_nxt;
  end

  assign cnt_ext = {{OUT_CNT_W{1'b0}}, count_r};

  assign in_req.ready         = (state_r == S_IDLE);
  assign out_rsp.valid        = (state_r == S_OUT);
  assign out_rsp.popped_value = popped_r;
  assign out_rsp.status       = status_r;
  assign out_rsp.count        = cnt_ext[OUT_CNT_W-1:0];

  `BDQ_ASSERT(a_count_bound, count_r <= CAP_CNT, "entry count above capacity")
  `BDQ_ASSERT(a_full_status, (out_rsp.valid && status_r == ST_FULL) |-> full, "full status while not full")
  `BDQ_ASSERT(a_empty_status, (out_rsp.valid && status_r == ST_EMPTY) |-> (empty && popped_r == '0), "empty status with entries or data")
  `BDQ_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE && count_r == '0), "not idle and empty after reset")

endmodule

[rtl/bdq_ram.sv]
// generic simple dual-port ram with registered read
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/bdq_addr.sv]
// circular index unit: base plus offset modulo the capacity
module bdq_addr #(
  parameter int CAPACITY = 16,
  parameter int IDX_W    = $clog2(CAPACITY)
) (
  input  logic [IDX_W-1:0] base,
  input  logic [IDX_W-1:0] off,
  output logic [IDX_W-1:0] phys
);

  localparam logic [IDX_W:0] CAP_S = (IDX_W+1)'(CAPACITY);

  logic [IDX_W:0] sum;

  // both operands are below the capacity, so one subtract wraps
  always_comb begin
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= CAP_S) begin
      phys = IDX_W'(sum - CAP_S);
    end else begin
      phys = sum[IDX_W-1:0];
    end
  end

endmodule
